// ===== rtl/core/ppt_pkg.sv =====
package ppt_pkg;

  // Fixed field widths
  localparam int WEIGHT_W = 32;
  localparam int COUNT_W  = 8;
  localparam int INDEX_W  = 4;
  localparam int MAX_FEATURES = 10;

  // Request codes carried on req_type
  localparam logic REQ_TRAIN = 1'b0;
  localparam logic REQ_DUMP  = 1'b1;

  // Saturation bounds of a weight
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] TARGET_RUN_RESET = 8'd10;

  // Per-lane control from the sequencer
  typedef struct packed {
    logic load;       // capture feature and product
    logic upd_en;     // apply the perceptron update
    logic neg;        // target is -1: subtract the feature
    logic pocket_en;  // copy the weight into the pocket
  } lane_ctl_t;

endpackage

// ===== rtl/core/ppt_lane.sv =====
module ppt_lane #(
  parameter int FEATURE_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  ppt_pkg::lane_ctl_t                            ctl,
  input  logic signed [FEATURE_BITS-1:0]                feature,
  output logic signed [ppt_pkg::WEIGHT_W+FEATURE_BITS-1:0] product,
  output logic signed [ppt_pkg::WEIGHT_W-1:0]           pocket
);
  import ppt_pkg::*;

  localparam int PROD_W = WEIGHT_W + FEATURE_BITS;

  logic signed [WEIGHT_W-1:0]     weight;
  logic signed [WEIGHT_W-1:0]     weight_next;
  logic signed [FEATURE_BITS-1:0] feat;
  logic signed [PROD_W-1:0]       mul_full;
  logic signed [WEIGHT_W:0]       wide_w;
  logic signed [WEIGHT_W:0]       wide_x;
  logic signed [WEIGHT_W:0]       wide_sum;

  // Exact product of the live weight and the incoming feature
  assign mul_full = weight * feature;

  // Add or subtract the held feature, clamp to the weight range
  assign wide_w   = (WEIGHT_W+1)'(weight);
  assign wide_x   = (WEIGHT_W+1)'(feat);
  assign wide_sum = ctl.neg ? (wide_w - wide_x) : (wide_w + wide_x);

  always_comb begin
    if (wide_sum[WEIGHT_W] != wide_sum[WEIGHT_W-1]) begin
      weight_next = wide_sum[WEIGHT_W] ? WEIGHT_MIN : WEIGHT_MAX;
    end else begin
      weight_next = wide_sum[WEIGHT_W-1:0];
    end
  end

  // Weight and pocket copy
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
      pocket <= '0;
    end else begin
      if (ctl.upd_en) begin
        weight <= weight_next;
      end
      if (ctl.pocket_en) begin
        pocket <= weight;
      end
    end
  end

  // Capture feature and product for the merge stage
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      feat    <= feature;
      product <= mul_full;
    end
  end

endmodule

// ===== rtl/core/ppt_merge.sv =====
module ppt_merge #(
  parameter int N_LANES = 10,
  parameter int PROD_W  = 48
) (
  input  logic signed [PROD_W-1:0] products [N_LANES],
  input  logic                     neg,
  output logic                     ok
);
  import ppt_pkg::*;

  localparam int SUM_W = PROD_W + $clog2(N_LANES + 1);

  logic signed [SUM_W-1:0] dot;

  // Sum the lane products
  always_comb begin
    dot = '0;
    for (int i = 0; i < N_LANES; i++) begin
      dot = dot + SUM_W'(products[i]);
    end
  end

  // Sign test against the target; zero is wrong
  assign ok = neg ? dot[SUM_W-1] : (!dot[SUM_W-1] && (dot != '0));

endmodule

// ===== rtl/core/pocket_perceptron_trainer.sv =====
// Pocket perceptron trainer. Each of the N_FEATURES lanes holds one weight and its pocket copy
// and multiplies the weight by its feature when a word is taken; once the output register can
// take a result, the decision stage sums the lane products, checks the sign against the target
// and, unless training is frozen, updates weights, run counts and pocket together. The loop runs
// from the weight registers through the multiply and the merge back into the weights; the next
// input word is taken the cycle after the update. A dump word returns one result per weight.
// Results pass through an output register, so a new word is taken while a result waits to be
// read. target_run is written through the cfg port, which is always ready; write it only while
// the block is idle. Reset clears all weights, pocket weights and counts.
module pocket_perceptron_trainer #(
  parameter int N_FEATURES   = 10,
  parameter int FEATURE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppt_pkg::COUNT_W-1:0]         cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                req_type,
  input  logic signed [FEATURE_BITS-1:0]      feature_0,
  input  logic signed [FEATURE_BITS-1:0]      feature_1,
  input  logic signed [FEATURE_BITS-1:0]      feature_2,
  input  logic signed [FEATURE_BITS-1:0]      feature_3,
  input  logic signed [FEATURE_BITS-1:0]      feature_4,
  input  logic signed [FEATURE_BITS-1:0]      feature_5,
  input  logic signed [FEATURE_BITS-1:0]      feature_6,
  input  logic signed [FEATURE_BITS-1:0]      feature_7,
  input  logic signed [FEATURE_BITS-1:0]      feature_8,
  input  logic signed [FEATURE_BITS-1:0]      feature_9,
  input  logic                                class_is_one,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                correct,
  output logic [ppt_pkg::COUNT_W-1:0]         run_length,
  output logic [ppt_pkg::COUNT_W-1:0]         best_run,
  output logic                                done_res,
  output logic [ppt_pkg::INDEX_W-1:0]         weight_index,
  output logic signed [ppt_pkg::WEIGHT_W-1:0] weight_value,
  output logic                                last
);
  import ppt_pkg::*;

  localparam int PROD_W = WEIGHT_W + FEATURE_BITS;
  localparam int IDX_W  = (N_FEATURES > 1) ? $clog2(N_FEATURES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_FEATURES - 1);

  logic signed [FEATURE_BITS-1:0] feat [MAX_FEATURES];
  logic signed [PROD_W-1:0]       products [N_FEATURES];
  logic signed [WEIGHT_W-1:0]     pocket_w [N_FEATURES];

  logic [COUNT_W-1:0] target_run;
  logic [COUNT_W-1:0] run_count;
  logic [COUNT_W-1:0] best_count;
  logic               frozen;
  logic [COUNT_W-1:0] run_next;
  logic [COUNT_W-1:0] best_next;
  logic               frozen_next;

  logic               s1_valid;
  logic               s1_dump;
  logic               s1_neg;
  logic [IDX_W-1:0]   dump_idx;

  logic               accept;
  logic               load_out;
  logic               fire;
  logic               train_fire;
  logic               dump_fire;
  logic               ok;
  logic               beat_best;
  lane_ctl_t          lane_ctl;

  assign feat[0] = feature_0;
  assign feat[1] = feature_1;
  assign feat[2] = feature_2;
  assign feat[3] = feature_3;
  assign feat[4] = feature_4;
  assign feat[5] = feature_5;
  assign feat[6] = feature_6;
  assign feat[7] = feature_7;
  assign feat[8] = feature_8;
  assign feat[9] = feature_9;

  // Handshakes
  assign cfg_ready  = 1'b1;
  assign in_stall   = s1_valid;
  assign accept     = in_valid && !in_stall;
  assign load_out   = !out_valid || !out_stall;
  assign fire       = s1_valid && load_out;
  assign dump_fire  = fire && s1_dump;
  assign train_fire = fire && !s1_dump && !frozen;

  // Counter updates for a processed training word
  assign run_next    = ok ? ((run_count == COUNT_MAX) ? run_count : run_count + 1'b1) : '0;
  assign beat_best   = ok && (run_next > best_count);
  assign best_next   = beat_best ? run_next : best_count;
  assign frozen_next = frozen || (best_next >= target_run);

  assign lane_ctl.load      = accept;
  assign lane_ctl.upd_en    = train_fire && !ok;
  assign lane_ctl.neg       = s1_neg;
  assign lane_ctl.pocket_en = train_fire && beat_best;

  // Lanes
  for (genvar i = 0; i < N_FEATURES; i++) begin : g_lane
    ppt_lane #(
      .FEATURE_BITS(FEATURE_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (lane_ctl),
      .feature(feat[i]),
      .product(products[i]),
      .pocket (pocket_w[i])
    );
  end

  // Merge the lane products into the classification
  ppt_merge #(
    .N_LANES(N_FEATURES),
    .PROD_W (PROD_W)
  ) u_merge (
    .products(products),
    .neg     (s1_neg),
    .ok      (ok)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_run <= TARGET_RUN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      target_run <= cfg_data;
    end
  end

  // Hold the word in the decision stage; step through the dump
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_dump  <= 1'b0;
      s1_neg   <= 1'b0;
      dump_idx <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        s1_dump  <= (req_type == REQ_DUMP);
        s1_neg   <= class_is_one;
      end else if (fire) begin
        if (!s1_dump || (dump_idx == LAST_IDX)) begin
          s1_valid <= 1'b0;
          dump_idx <= '0;
        end else begin
          dump_idx <= dump_idx + 1'b1;
        end
      end
    end
  end

  // Run counters and freeze flag
  always_ff @(posedge clk) begin
    if (rst) begin
      run_count  <= '0;
      best_count <= '0;
      frozen     <= 1'b0;
    end else if (train_fire) begin
      run_count  <= run_next;
      best_count <= best_next;
      frozen     <= frozen_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (dump_fire) begin
        correct      <= 1'b0;
        run_length   <= run_count;
        best_run     <= best_count;
        done_res     <= frozen;
        weight_index <= INDEX_W'(dump_idx);
        weight_value <= pocket_w[dump_idx];
        last         <= (dump_idx == LAST_IDX);
      end else if (frozen) begin
        correct      <= 1'b0;
        run_length   <= run_count;
        best_run     <= best_count;
        done_res     <= 1'b1;
        weight_index <= '0;
        weight_value <= '0;
        last         <= 1'b1;
      end else begin
        correct      <= ok;
        run_length   <= run_next;
        best_run     <= best_next;
        done_res     <= frozen_next;
        weight_index <= '0;
        weight_value <= '0;
        last         <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_frozen_sticks: assert property (@(posedge clk) disable iff (rst)
    frozen |=> frozen)
    else $error("freeze flag dropped");

  a_run_within_best: assert property (@(posedge clk) disable iff (rst)
    run_count <= best_count)
    else $error("run count above best run");

  a_update_or_pocket: assert property (@(posedge clk) disable iff (rst)
    !(lane_ctl.upd_en && lane_ctl.pocket_en))
    else $error("weight update and pocket copy together");

  a_dump_idx_owned: assert property (@(posedge clk) disable iff (rst)
    (dump_idx != '0) |-> (s1_valid && s1_dump))
    else $error("dump index moved outside a dump");

  a_train_gives_result: assert property (@(posedge clk) disable iff (rst)
    (fire && !s1_dump) |=> (out_valid && last))
    else $error("training word left no result");
`endif

endmodule
